FILE: hw/rtl/linear_scan_key_value_table_unit_macros.svh
// Assertion macros shared by the key/value table RTL.
`ifndef LINEAR_SCAN_KEY_VALUE_TABLE_UNIT_MACROS_SVH
`define LINEAR_SCAN_KEY_VALUE_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked on every clock edge outside reset.
`define LSKV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lskv assertion failed");
// Condition that must never hold outside reset.
`define LSKV_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("lskv assertion failed");
`else
`define LSKV_ASSERT_IMP(lbl, ante, cons)
`define LSKV_ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: hw/rtl/lskv_pkg.sv
// Shared types and constants for the linear-scan key/value table.
package lskv_pkg;

    localparam int ENTRIES_DEF    = 64;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // Command codes carried on the input tuser
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_UPSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        RES_OK        = 2'd0,
        RES_DUPLICATE = 2'd1,
        RES_NOT_FOUND = 2'd2,
        RES_FULL      = 2'd3
    } t_res;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    // Compare unit verdict for one slot
    typedef struct packed {
        logic deleted;
        logic key_eq;
        logic live_match;
    } t_cmp;

endpackage

FILE: hw/rtl/lskv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lskv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/lskv_cmp.sv
// Slot compare unit: tombstone flag, key equality and live match.
module lskv_cmp #(
    parameter int KEY_BITS   = lskv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lskv_pkg::VALUE_BITS_DEF
) (
    input  logic [KEY_BITS-1:0]              i_key,
    input  logic [KEY_BITS+VALUE_BITS:0]     i_slot,
    output lskv_pkg::t_cmp                   o_cmp
);

    // slot word: {deleted, key, value}
    logic                deleted;
    logic [KEY_BITS-1:0] slot_key;

    assign deleted  = i_slot[KEY_BITS+VALUE_BITS];
    assign slot_key = i_slot[KEY_BITS+VALUE_BITS-1:VALUE_BITS];

    always_comb begin
        o_cmp.deleted    = deleted;
        o_cmp.key_eq     = (slot_key == i_key);
        o_cmp.live_match = !deleted && (slot_key == i_key);
    end

endmodule

FILE: hw/rtl/linear_scan_key_value_table_unit.sv
// Top level of the linear-scan key/value table with tombstones.
// A command is taken in idle; the scan then reads one slot per cycle up to the end mark,
// stopping early once a slot settles the command, and the result is then queued.
// Throughput: one command at a time; the next is taken once the result is queued.
// Reset (synchronous, active low) empties the table by clearing the end mark.
`include "linear_scan_key_value_table_unit_macros.svh"
module linear_scan_key_value_table_unit #(
    parameter int ENTRIES    = lskv_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lskv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lskv_pkg::VALUE_BITS_DEF,
    parameter int CW         = $clog2(ENTRIES + 1),
    parameter int IN_W       = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
    parameter int OUT_W      = ((2 + VALUE_BITS + CW + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // slave side
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,  // key, new_value
    input  logic [1:0]       i_s_tuser,  // command
    // master side
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata   // status, found_value, deleted_count
);

    localparam int AW = $clog2(ENTRIES);
    localparam int WW = 1 + KEY_BITS + VALUE_BITS;

    // control and payload registers
    lskv_pkg::t_state      r_state, n_state;
    lskv_pkg::t_cmd        r_cmd, n_cmd;
    lskv_pkg::t_res        r_res, n_res;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [CW-1:0]         r_end, n_end;
    logic [CW-1:0]         r_rd_addr, n_rd_addr;
    logic                  r_dv, n_dv;
    logic [AW-1:0]         r_dv_idx, n_dv_idx;
    logic [CW-1:0]         r_count, n_count;
    logic [VALUE_BITS-1:0] r_found, n_found;
    logic                  r_m_valid, n_m_valid;
    logic [OUT_W-1:0]      r_m_data, n_m_data;

    // RAM and compare unit
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [WW-1:0]         wr_data;
    logic                  rd_en;
    logic [WW-1:0]         rd_data;
    lskv_pkg::t_cmp        cmp;
    logic                  stop;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;

    // result register fields for the checks
    logic [1:0]            m_status;
    logic [OUT_W-3:0]      m_payload;

    assign rd_key = rd_data[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
    assign rd_val = rd_data[VALUE_BITS-1:0];

    lskv_ram #(
        .WIDTH (WW),
        .DEPTH (ENTRIES)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    lskv_cmp #(
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_cmp (
        .i_key  (r_key),
        .i_slot (rd_data),
        .o_cmp  (cmp)
    );

    // sequencer: accept, scan one slot per cycle, queue the result
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_res     = r_res;
        n_key     = r_key;
        n_val     = r_val;
        n_end     = r_end;
        n_rd_addr = r_rd_addr;
        n_dv      = 1'b0;
        n_dv_idx  = r_dv_idx;
        n_count   = r_count;
        n_found   = r_found;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        wr_en     = 1'b0;
        wr_addr   = r_dv_idx;
        wr_data   = {1'b0, r_key, r_val};
        rd_en     = 1'b0;
        stop      = 1'b0;

        // output transfer frees the result register
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            lskv_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd     = lskv_pkg::t_cmd'(i_s_tuser);
                    n_key     = i_s_tdata[KEY_BITS-1:0];
                    n_val     = i_s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
                    n_rd_addr = '0;
                    n_count   = '0;
                    n_found   = '0;
                    n_res     = lskv_pkg::RES_OK;
                    n_state   = lskv_pkg::S_SCAN;
                end
            end

            lskv_pkg::S_SCAN: begin
                // check the slot read in the previous cycle
                if (r_dv) begin
                    case (r_cmd)
                        lskv_pkg::CMD_INSERT, lskv_pkg::CMD_UPSERT: begin
                            if (cmp.deleted) begin
                                wr_en = 1'b1;
                                stop  = 1'b1;
                                n_res = lskv_pkg::RES_OK;
                            end else if (cmp.key_eq) begin
                                stop = 1'b1;
                                if (r_cmd == lskv_pkg::CMD_UPSERT) begin
                                    wr_en = 1'b1;
                                    n_res = lskv_pkg::RES_OK;
                                end else begin
                                    n_res = lskv_pkg::RES_DUPLICATE;
                                end
                            end
                        end
                        lskv_pkg::CMD_DELETE: begin
                            if (cmp.live_match) begin
                                wr_en   = 1'b1;
                                wr_data = {1'b1, rd_key, rd_val};
                                n_count = r_count + CW'(1);
                            end
                        end
                        lskv_pkg::CMD_QUERY: begin
                            if (cmp.live_match) begin
                                stop    = 1'b1;
                                n_found = rd_val;
                                n_res   = lskv_pkg::RES_OK;
                            end
                        end
                        default: ;
                    endcase
                end

                // issue the next read below the end mark
                rd_en    = !stop && (r_rd_addr < r_end);
                n_dv     = rd_en;
                n_dv_idx = r_rd_addr[AW-1:0];
                if (rd_en) begin
                    n_rd_addr = r_rd_addr + CW'(1);
                end

                if (stop) begin
                    n_state = lskv_pkg::S_FIN;
                end else if (!r_dv && !rd_en) begin
                    // scan ran out at the end mark
                    case (r_cmd)
                        lskv_pkg::CMD_INSERT, lskv_pkg::CMD_UPSERT: begin
                            if (r_end == CW'(ENTRIES)) begin
                                n_res = lskv_pkg::RES_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_end[AW-1:0];
                                n_end   = r_end + CW'(1);
                                n_res   = lskv_pkg::RES_OK;
                            end
                        end
                        lskv_pkg::CMD_DELETE: begin
                            n_res = (r_count != '0) ? lskv_pkg::RES_OK
                                                    : lskv_pkg::RES_NOT_FOUND;
                        end
                        lskv_pkg::CMD_QUERY: begin
                            n_res = lskv_pkg::RES_NOT_FOUND;
                        end
                        default: ;
                    endcase
                    n_state = lskv_pkg::S_FIN;
                end
            end

            lskv_pkg::S_FIN: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = OUT_W'({r_count, r_found, r_res});
                    n_state   = lskv_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = lskv_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lskv_pkg::S_IDLE;
            r_end     <= '0;
            r_dv      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_end     <= n_end;
            r_dv      <= n_dv;
            r_m_valid <= n_m_valid;
        end
        r_cmd     <= n_cmd;
        r_res     <= n_res;
        r_key     <= n_key;
        r_val     <= n_val;
        r_rd_addr <= n_rd_addr;
        r_dv_idx  <= n_dv_idx;
        r_count   <= n_count;
        r_found   <= n_found;
        r_m_data  <= n_m_data;
    end

    assign o_s_tready = (r_state == lskv_pkg::S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    assign m_status  = r_m_data[1:0];
    assign m_payload = r_m_data[OUT_W-1:2];

    // checks
    `LSKV_ASSERT_NEVER(a_end_in_range, r_end > CW'(ENTRIES))
    `LSKV_ASSERT_IMP(a_check_below_end, r_dv, CW'(r_dv_idx) < r_end)
    `LSKV_ASSERT_IMP(a_idle_no_read, o_s_tready, !r_dv)
    `LSKV_ASSERT_IMP(a_err_no_data, r_m_valid && (m_status != lskv_pkg::RES_OK), m_payload == '0)

endmodule
